// ----- design/ntaf_pkg.sv -----
package ntaf_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_A    = 8'd65;
   localparam logic [CHAR_WIDTH-1:0] ASCII_X    = 8'd88;
   localparam logic [CHAR_WIDTH-1:0] DIGIT_BASE = 8'd10;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   mode;
   } req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  last;
   } rsp_type;

   // commands from the sequencer to the digit shift register
   typedef struct packed {
      logic clear;
      logic dabble;
      logic bit_in;
      logic digit_shift;
   } bcd_cmd_type;

   function automatic logic [CHAR_WIDTH-1:0] hex_char(input logic [DIGIT_WIDTH-1:0] nibble);
      logic [CHAR_WIDTH-1:0] wide;
      wide = {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, nibble};
      if (nibble > 4'd9) begin
         return ASCII_A - DIGIT_BASE + wide;
      end
      return ASCII_ZERO + wide;
   endfunction

endpackage

// ----- design/ntaf_bcd_shifter.sv -----
module ntaf_bcd_shifter
   import ntaf_pkg::*;
#(
   parameter int MAX_DIGITS = 10
) (
   input  logic                   clock,
   input  bcd_cmd_type            cmd,
   output logic [DIGIT_WIDTH-1:0] top_digit,
   output logic                   overflow
);

   localparam int BCD_WIDTH = MAX_DIGITS * DIGIT_WIDTH;

   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0] adjusted;
   logic                 overflow_ff, overflow_in;

   // add 3 to every digit of 5 or more before the doubling shift
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_WIDTH +: DIGIT_WIDTH] >= 4'd5) begin
            adjusted[d*DIGIT_WIDTH +: DIGIT_WIDTH] =
               bcd_ff[d*DIGIT_WIDTH +: DIGIT_WIDTH] + 4'd3;
         end else begin
            adjusted[d*DIGIT_WIDTH +: DIGIT_WIDTH] = bcd_ff[d*DIGIT_WIDTH +: DIGIT_WIDTH];
         end
      end
   end

   always_comb begin
      bcd_in      = bcd_ff;
      overflow_in = overflow_ff;
      if (cmd.clear) begin
         bcd_in      = '0;
         overflow_in = 1'b0;
      end else if (cmd.dabble) begin
         // a one leaving the top digit means the value has more digits than fit
         bcd_in      = (adjusted << 1) | {{(BCD_WIDTH-1){1'b0}}, cmd.bit_in};
         overflow_in = overflow_ff | adjusted[BCD_WIDTH-1];
      end else if (cmd.digit_shift) begin
         bcd_in = bcd_ff << DIGIT_WIDTH;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      overflow_ff <= overflow_in;
   end

   assign top_digit = bcd_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];
   assign overflow  = overflow_ff;

endmodule

// ----- design/number_to_ascii_formatter_core.sv -----
// Decimal word: accept, binary-to-BCD conversion by shift-and-add-3 (one
// input bit per cycle), then step over leading zeros and emit one character
// per cycle while the output is not stalled. A new word is accepted only in
// idle, once the sequencer has finished the previous word.
// Hex word: accept, then 4 characters, one per cycle unless the output stalls.
// Synchronous active-high reset returns the sequencer to idle with no output.
module number_to_ascii_formatter_core
   import ntaf_pkg::*;
#(
   parameter int MAX_DIGITS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int REMAIN_WIDTH  = $clog2(MAX_DIGITS + 1);

   typedef enum logic [2:0] {
      IDLE,
      CONVERT,
      SKIP,
      EMIT,
      HEX
   } state_type;

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   value_ff, value_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [REMAIN_WIDTH-1:0]  remain_ff, remain_in;
   logic [1:0]               hex_idx_ff, hex_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   bcd_cmd_type              cmd;
   logic [DIGIT_WIDTH-1:0]   top_digit;
   logic                     overflow;
   logic                     out_free;

   ntaf_bcd_shifter #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_bcd (
      .clock     (clock),
      .cmd       (cmd),
      .top_digit (top_digit),
      .overflow  (overflow)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      bit_cnt_in   = bit_cnt_ff;
      remain_in    = remain_ff;
      hex_idx_in   = hex_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cmd          = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               value_in   = req_payload.value;
               bit_cnt_in = BIT_CNT_WIDTH'(VALUE_WIDTH - 1);
               hex_idx_in = 2'd0;
               cmd.clear  = 1'b1;
               state_in   = req_payload.mode ? HEX : CONVERT;
            end
         end
         CONVERT: begin
            cmd.dabble = 1'b1;
            cmd.bit_in = value_ff[VALUE_WIDTH-1];
            value_in   = value_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               remain_in = REMAIN_WIDTH'(MAX_DIGITS);
               state_in  = SKIP;
            end
         end
         SKIP: begin
            // drop leading zeros, but keep all digits once the value overflowed
            if (top_digit == '0 && remain_ff > REMAIN_WIDTH'(1) && !overflow) begin
               cmd.digit_shift = 1'b1;
               remain_in       = remain_ff - 1'b1;
            end else begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.char_code = ASCII_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, top_digit};
               rsp_in.last      = (remain_ff == REMAIN_WIDTH'(1));
               cmd.digit_shift  = 1'b1;
               remain_in        = remain_ff - 1'b1;
               if (remain_ff == REMAIN_WIDTH'(1)) begin
                  state_in = IDLE;
               end
            end
         end
         HEX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = (hex_idx_ff == 2'd3);
               case (hex_idx_ff)
                  2'd0:    rsp_in.char_code = ASCII_ZERO;
                  2'd1:    rsp_in.char_code = ASCII_X;
                  2'd2:    rsp_in.char_code = hex_char(value_ff[7:4]);
                  default: rsp_in.char_code = hex_char(value_ff[3:0]);
               endcase
               hex_idx_in = hex_idx_ff + 1'b1;
               if (hex_idx_ff == 2'd3) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff   <= value_in;
      bit_cnt_ff <= bit_cnt_in;
      remain_ff  <= remain_in;
      hex_idx_ff <= hex_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready   = (state_ff == IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- tb/sv/number_to_ascii_formatter_core_test.sv -----
`timescale 1ns / 1ps

module number_to_ascii_formatter_core_test;
   import ntaf_pkg::*;

   localparam int DIGIT_LIMIT  = 10;
   localparam int RANDOM_WORDS = 209;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic MODE_DEC = 1'b0;
   localparam logic MODE_HEX = 1'b1;

   // Tracks the characters each accepted word must produce, in order.
   class char_ledger;
      rsp_type     pending_chars[$];
      logic [31:0] work_value;
      logic [3:0]  digit_store [DIGIT_LIMIT];
      int          digit_count;
      int          fault_count;

      function new();
         work_value  = '0;
         digit_count = 0;
         fault_count = 0;
      endfunction

      function logic [7:0] nibble_char(logic [3:0] nib);
         if (nib > 4'd9) begin
            return ASCII_A + 8'(nib) - 8'd10;
         end
         return ASCII_ZERO + 8'(nib);
      endfunction

      function void queue_char(logic [7:0] code, logic is_last);
         rsp_type c;
         c.char_code = code;
         c.last      = is_last;
         pending_chars.push_back(c);
      endfunction

      function void note_word(req_type w);
         int i;
         work_value = w.value;
         if (w.mode == MODE_HEX) begin
            queue_char(ASCII_ZERO, 1'b0);
            queue_char(ASCII_X, 1'b0);
            queue_char(nibble_char(w.value[7:4]), 1'b0);
            queue_char(nibble_char(w.value[3:0]), 1'b1);
            return;
         end
         digit_count = 0;
         if (work_value == 0) begin
            queue_char(ASCII_ZERO, 1'b1);
            return;
         end
         while (work_value != 0 && digit_count < DIGIT_LIMIT) begin
            digit_store[digit_count] = 4'(work_value % 10);
            work_value  = work_value / 10;
            digit_count = digit_count + 1;
         end
         work_value = '0;
         for (i = digit_count - 1; i >= 0; i--) begin
            queue_char(ASCII_ZERO + 8'(digit_store[i]), i == 0);
         end
      endfunction

      function void flag(string msg);
         fault_count++;
         if (fault_count <= 10) begin
            $display("mismatch at %0t: %s", $time, msg);
         end
      endfunction

      function void check_char(rsp_type got);
         rsp_type want;
         if (pending_chars.size() == 0) begin
            flag($sformatf("unexpected char %h last %b", got.char_code, got.last));
            return;
         end
         want = pending_chars.pop_front();
         if (got.char_code !== want.char_code || got.last !== want.last) begin
            flag($sformatf("char expected %h last %b, got %h last %b",
                           want.char_code, want.last, got.char_code, got.last));
         end
      endfunction
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   logic calm    = 1'b0;
   logic rx_hold = 1'b0;
   int   rx_wait = 0;
   int   words_sent  = 0;
   int   cycle_count = 0;

   char_ledger ledger = new();

   number_to_ascii_formatter_core #(
      .MAX_DIGITS(DIGIT_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("number_to_ascii_formatter_core_test NOT OK");
         $finish;
      end
   end

   // Result side: check each accepted character, then, unless calm, back off for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            ledger.check_char(rsp_payload);
            rx_wait = calm ? 0 : $urandom_range(0, 10);
         end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
         end
         rsp_ready <= (rx_wait == 0) && !rx_hold;
      end
   end

   // Long hold-off on the result side while words keep arriving, so the core backs up.
   initial begin
      while (words_sent < 30) @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   task automatic send_word(input logic [31:0] v, input logic m);
      req_type w;
      int      gap;
      w.value = v;
      w.mode  = m;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (!req_ready);
      ledger.note_word(w);
      words_sent = words_sent + 1;
   endtask

   task automatic send_random_word();
      logic [31:0] v;
      logic [31:0] tens;
      int          span;
      logic        m;
      m = ($urandom_range(0, 9) < 3) ? MODE_HEX : MODE_DEC;
      if ($urandom_range(0, 7) == 0) begin
         // land next to a power of ten, where the digit count changes
         tens = 1;
         repeat ($urandom_range(0, 9)) tens = tens * 10;
         v = tens + $urandom_range(0, 2) - 1;
      end else begin
         span = $urandom_range(1, 32);
         v = $urandom;
         if (span < 32) begin
            v = v & ((32'h1 << span) - 1);
         end
      end
      send_word(v, m);
   endtask

   initial begin
      int k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_word(32'd0, MODE_DEC);
      send_word(32'd0, MODE_HEX);
      send_word(32'hFFFF_FFFF, MODE_DEC);
      send_word(32'hFFFF_FFFF, MODE_HEX);
      send_word(32'd1, MODE_DEC);
      send_word(32'd9, MODE_DEC);
      send_word(32'd10, MODE_DEC);
      send_word(32'd99, MODE_DEC);
      send_word(32'd100, MODE_DEC);
      send_word(32'd999_999_999, MODE_DEC);
      send_word(32'd1_000_000_000, MODE_DEC);
      send_word(32'd4_294_967_294, MODE_DEC);
      send_word(32'd12_345_678, MODE_DEC);
      send_word(32'hAAAA_AAAA, MODE_DEC);
      send_word(32'h5555_5555, MODE_DEC);
      send_word(32'h8000_0000, MODE_DEC);
      send_word(32'h0000_00AB, MODE_HEX);
      send_word(32'h0000_000F, MODE_HEX);
      send_word(32'h0000_00F0, MODE_HEX);
      send_word(32'h1234_569A, MODE_HEX);
      send_word(32'hFFFF_FF00, MODE_HEX);

      for (k = 0; k < RANDOM_WORDS; k++) begin
         calm <= ((k / 25) % 4 == 2);
         send_random_word();
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      while (ledger.pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.fault_count == 0 && ledger.pending_chars.size() == 0) begin
         $display("number_to_ascii_formatter_core_test OK");
      end else begin
         $display("number_to_ascii_formatter_core_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ntaf_pkg.sv
design/ntaf_bcd_shifter.sv
design/number_to_ascii_formatter_core.sv
tb/sv/number_to_ascii_formatter_core_test.sv
